// ----- sv/ptq_pkg.sv -----
// Package for the process table with priority queues.
// Holds the item structs, command and status codes, and the sequencer states.
// No dependencies.
package ptq_pkg;

  // Command codes
  localparam logic [3:0] OP_CREATE  = 4'd0;
  localparam logic [3:0] OP_DELETE  = 4'd1;
  localparam logic [3:0] OP_BLOCK   = 4'd2;
  localparam logic [3:0] OP_UNBLOCK = 4'd3;
  localparam logic [3:0] OP_SUSPEND = 4'd4;
  localparam logic [3:0] OP_RESUME  = 4'd5;
  localparam logic [3:0] OP_SETPRIO = 4'd6;
  localparam logic [3:0] OP_SHOW    = 4'd7;
  localparam logic [3:0] OP_LIST    = 4'd8;

  // Status codes
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_USED   = 2'd1;
  localparam logic [1:0] STS_NOPROC = 2'd2;
  localparam logic [1:0] STS_WRONG  = 2'd3;

  // Process states; each state also names its queue
  localparam logic [1:0] PST_READY = 2'd0;
  localparam logic [1:0] PST_BLK   = 2'd1;
  localparam logic [1:0] PST_SRDY  = 2'd2;
  localparam logic [1:0] PST_SBLK  = 2'd3;

  // List selector
  localparam logic [2:0] SEL_ALL = 3'd0;
  localparam logic [2:0] SEL_MAX = 3'd4;

  typedef struct packed {
    logic [3:0]        operation;
    logic [3:0]        process_id;
    logic signed [7:0] priority_req;
    logic              process_class;
    logic [2:0]        queue_select;
  } ptq_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              entry_present;
    logic [3:0]        out_id;
    logic signed [7:0] out_priority;
    logic              out_class;
    logic [1:0]        out_state;
    logic              last;
  } ptq_out_t;

  // Per-field write enables of the entry memory
  typedef struct packed {
    logic st;
    logic pr;
    logic cl;
    logic nx;
    logic pv;
  } ptq_wen_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_UNL1,
    S_UNL2,
    S_INS,
    S_INS_CMP,
    S_INS_W1,
    S_INS_W2,
    S_INS_W3,
    S_APP1,
    S_APP2,
    S_DONE,
    S_LSCAN,
    S_LOUT
  } ptq_fsm_t;

endpackage

// ----- sv/ptq_entry_ram.sv -----
// Entry memory of the process table: state, priority, class and both links.
// One write port with per-field enables, one read port with registered data.
// Depends on ptq_pkg.
module ptq_entry_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic [AW-1:0]     wr_addr,
  input  ptq_pkg::ptq_wen_t wen,
  input  logic [1:0]        wr_st,
  input  logic [7:0]        wr_pr,
  input  logic              wr_cl,
  input  logic [AW-1:0]     wr_nx,
  input  logic [AW-1:0]     wr_pv,
  input  logic [AW-1:0]     rd_addr,
  output logic [1:0]        rd_st,
  output logic [7:0]        rd_pr,
  output logic              rd_cl,
  output logic [AW-1:0]     rd_nx,
  output logic [AW-1:0]     rd_pv
);
  import ptq_pkg::*;

  typedef struct packed {
    logic [1:0]    st;
    logic [7:0]    pr;
    logic          cl;
    logic [AW-1:0] nx;
    logic [AW-1:0] pv;
  } ent_t;

  ent_t mem [DEPTH];
  ent_t rd_q_r;

  // Field-masked write
  always_ff @(posedge clk) begin
    if (wen.st) mem[wr_addr].st <= wr_st;
    if (wen.pr) mem[wr_addr].pr <= wr_pr;
    if (wen.cl) mem[wr_addr].cl <= wr_cl;
    if (wen.nx) mem[wr_addr].nx <= wr_nx;
    if (wen.pv) mem[wr_addr].pv <= wr_pv;
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
  end

  assign rd_st = rd_q_r.st;
  assign rd_pr = rd_q_r.pr;
  assign rd_cl = rd_q_r.cl;
  assign rd_nx = rd_q_r.nx;
  assign rd_pv = rd_q_r.pv;

endmodule

// ----- sv/process_table_priority_queues.sv -----
// Show and error items give their one result from the decode state; moves walk the target
// ordered queue one entry per cycle. List: scans the selected queues in order; results back
// to back per queue. One item at a time: busy stays high until the item's last result is
// out; rate is set by the entry memory walk. Results cannot be stalled.
// Reset (rst_n low, synchronous) empties the table and all four queues at once.
module process_table_priority_queues #(
  parameter int NUM_PROCS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ptq_pkg::ptq_in_t  in_item,
  output logic              busy,
  output logic              out_strobe,
  output ptq_pkg::ptq_out_t out_item
);
  import ptq_pkg::*;

  localparam int AW = $clog2(NUM_PROCS);

  ptq_fsm_t state_r, state_nxt;

  // Command registers
  logic [3:0]     op_r;
  logic [AW-1:0]  id_r;
  logic [3:0]     id4_r;
  logic           idok_r;
  logic [7:0]     preq_r;
  logic           cls_r;
  logic [2:0]     sel_r;

  // Entry after the command, and its old links
  logic [7:0]     ent_prio_r;
  logic           ent_cls_r;
  logic [1:0]     ent_st_r;
  logic [AW-1:0]  lnk_n_r;
  logic [AW-1:0]  lnk_p_r;

  // Sequencer working registers
  logic [1:0]     unl_q_r;
  logic [1:0]     ins_q_r;
  logic           do_ins_r;
  logic           fin_r;
  logic [AW-1:0]  cur_r;
  logic [AW-1:0]  ins_p_r;
  logic           at_head_r;
  logic [AW-1:0]  app_t_r;
  logic [2:0]     qcnt_r;
  logic [1:0]     lastq_r;
  logic           any_r;

  // Table control state
  logic [NUM_PROCS-1:0] valid_r;
  logic [AW-1:0]        head_r [4];
  logic [AW-1:0]        tail_r [4];
  logic [3:0]           ne_r;

  logic     out_v_r;
  ptq_out_t out_r;

  // Memory ports
  logic [AW-1:0] wr_addr, rd_addr;
  ptq_wen_t      wen;
  logic [1:0]    wr_st, rd_st;
  logic [7:0]    wr_pr, rd_pr;
  logic          wr_cl, rd_cl;
  logic [AW-1:0] wr_nx, wr_pv, rd_nx, rd_pv;

  // Decode results
  ptq_fsm_t   dec_state;
  logic       dec_err;
  logic [1:0] dec_code;
  logic       dec_show;
  logic [1:0] dec_new_st;
  logic [7:0] dec_prio;
  logic       pres;

  logic       lt;
  logic       later;
  logic [1:0] qsel;

  ptq_entry_ram #(.DEPTH(NUM_PROCS), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_addr (wr_addr),
    .wen     (wen),
    .wr_st   (wr_st),
    .wr_pr   (wr_pr),
    .wr_cl   (wr_cl),
    .wr_nx   (wr_nx),
    .wr_pv   (wr_pv),
    .rd_addr (rd_addr),
    .rd_st   (rd_st),
    .rd_pr   (rd_pr),
    .rd_cl   (rd_cl),
    .rd_nx   (rd_nx),
    .rd_pv   (rd_pv)
  );

  function automatic ptq_out_t mk_res(logic [1:0] sts, logic present, logic [3:0] id,
                                      logic [7:0] pr, logic cl, logic [1:0] st, logic lst);
    ptq_out_t r;
    r.status        = sts;
    r.entry_present = present;
    r.out_id        = id;
    r.out_priority  = pr;
    r.out_class     = cl;
    r.out_state     = st;
    r.last          = lst;
    return r;
  endfunction

  assign qsel = qcnt_r[1:0];
  assign lt   = $signed(rd_pr) < $signed(ent_prio_r);
  assign pres = idok_r && valid_r[id_r];

  // A later selected queue still holds entries
  always_comb begin
    later = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) > qcnt_r && 3'(i) <= {1'b0, lastq_r} && ne_r[i]) later = 1'b1;
    end
  end

  // Command decode against the entry read at accept
  always_comb begin
    dec_state  = S_IDLE;
    dec_err    = 1'b0;
    dec_code   = STS_OK;
    dec_show   = 1'b0;
    dec_new_st = rd_st;
    dec_prio   = (op_r == OP_CREATE || op_r == OP_SETPRIO) ? preq_r : rd_pr;
    if (op_r == OP_LIST) begin
      if (sel_r > SEL_MAX) begin
        dec_err  = 1'b1;
        dec_code = STS_WRONG;
      end else begin
        dec_state = S_LSCAN;
      end
    end else if (op_r > OP_LIST) begin
      dec_state = S_IDLE;
    end else if (!idok_r) begin
      dec_err  = 1'b1;
      dec_code = STS_NOPROC;
    end else if (op_r == OP_CREATE) begin
      dec_new_st = PST_READY;
      if (pres) begin
        dec_err  = 1'b1;
        dec_code = STS_USED;
      end else begin
        dec_state = S_INS;
      end
    end else if (!pres) begin
      dec_err  = 1'b1;
      dec_code = STS_NOPROC;
    end else begin
      case (op_r)
        OP_DELETE: begin
          dec_show  = 1'b1;
          dec_state = S_UNL1;
        end
        OP_BLOCK: begin
          if (rd_st == PST_BLK || rd_st == PST_SBLK) begin
            dec_err  = 1'b1;
            dec_code = STS_WRONG;
          end else begin
            dec_new_st = (rd_st == PST_READY) ? PST_BLK : PST_SBLK;
            dec_state  = S_UNL1;
          end
        end
        OP_UNBLOCK: begin
          if (rd_st == PST_READY || rd_st == PST_SRDY) begin
            dec_err  = 1'b1;
            dec_code = STS_WRONG;
          end else begin
            dec_new_st = (rd_st == PST_BLK) ? PST_READY : PST_SRDY;
            dec_state  = S_UNL1;
          end
        end
        OP_SUSPEND: begin
          if (rd_st[1]) begin
            dec_err  = 1'b1;
            dec_code = STS_WRONG;
          end else begin
            dec_new_st = {1'b1, rd_st[0]};
            dec_state  = S_UNL1;
          end
        end
        OP_RESUME: begin
          if (!rd_st[1]) begin
            dec_err  = 1'b1;
            dec_code = STS_WRONG;
          end else begin
            dec_new_st = {1'b0, rd_st[0]};
            dec_state  = S_UNL1;
          end
        end
        OP_SETPRIO: begin
          // ordered queues re-insert, blocked queues keep their place
          dec_state = rd_st[0] ? S_DONE : S_UNL1;
        end
        OP_SHOW: begin
          dec_show = 1'b1;
        end
        default: begin
          dec_state = S_IDLE;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (start) state_nxt = S_DEC;
      S_DEC:     state_nxt = dec_state;
      S_UNL1: begin
        if (ne_r[unl_q_r] && !(head_r[unl_q_r] == id_r && tail_r[unl_q_r] == id_r) &&
            tail_r[unl_q_r] != id_r) begin
          state_nxt = S_UNL2;
        end else begin
          state_nxt = do_ins_r ? S_INS : (fin_r ? S_DONE : S_IDLE);
        end
      end
      S_UNL2:    state_nxt = do_ins_r ? S_INS : (fin_r ? S_DONE : S_IDLE);
      S_INS:     state_nxt = (ins_q_r[0] || !ne_r[ins_q_r]) ? S_APP1 : S_INS_CMP;
      S_INS_CMP: begin
        if (lt) state_nxt = S_INS_W1;
        else if (cur_r == tail_r[ins_q_r]) state_nxt = S_APP1;
        else state_nxt = S_INS_CMP;
      end
      S_INS_W1:  state_nxt = at_head_r ? S_INS_W3 : S_INS_W2;
      S_INS_W2:  state_nxt = S_INS_W3;
      S_INS_W3:  state_nxt = S_DONE;
      S_APP1:    state_nxt = ne_r[ins_q_r] ? S_APP2 : S_DONE;
      S_APP2:    state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      S_LSCAN: begin
        if (qcnt_r > {1'b0, lastq_r}) state_nxt = S_IDLE;
        else if (ne_r[qsel]) state_nxt = S_LOUT;
        else state_nxt = S_LSCAN;
      end
      S_LOUT:    state_nxt = (cur_r == tail_r[qsel]) ? S_LSCAN : S_LOUT;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Memory accesses per state
  always_comb begin
    wen     = '0;
    wr_addr = id_r;
    wr_st   = dec_new_st;
    wr_pr   = preq_r;
    wr_cl   = cls_r;
    wr_nx   = id_r;
    wr_pv   = id_r;
    rd_addr = cur_r;
    case (state_r)
      S_IDLE: rd_addr = AW'(in_item.process_id);
      S_DEC: begin
        if (!dec_err && dec_state != S_IDLE && op_r != OP_LIST && op_r != OP_DELETE) begin
          wen.st = (op_r != OP_SETPRIO);
          wen.pr = (op_r == OP_CREATE || op_r == OP_SETPRIO);
          wen.cl = (op_r == OP_CREATE);
        end
      end
      S_UNL1: begin
        if (ne_r[unl_q_r] && !(head_r[unl_q_r] == id_r && tail_r[unl_q_r] == id_r) &&
            head_r[unl_q_r] != id_r) begin
          wr_addr = lnk_p_r;
          wen.nx  = 1'b1;
          wr_nx   = lnk_n_r;
        end
      end
      S_UNL2: begin
        wr_addr = lnk_n_r;
        wen.pv  = 1'b1;
        wr_pv   = lnk_p_r;
      end
      S_INS:     rd_addr = head_r[ins_q_r];
      S_INS_CMP: rd_addr = rd_nx;
      S_INS_W1: begin
        wen.nx = 1'b1;
        wr_nx  = cur_r;
        wen.pv = !at_head_r;
        wr_pv  = ins_p_r;
      end
      S_INS_W2: begin
        wr_addr = ins_p_r;
        wen.nx  = 1'b1;
      end
      S_INS_W3: begin
        wr_addr = cur_r;
        wen.pv  = 1'b1;
      end
      S_APP1: begin
        if (ne_r[ins_q_r]) begin
          wr_addr = tail_r[ins_q_r];
          wen.nx  = 1'b1;
        end
      end
      S_APP2: begin
        wen.pv = 1'b1;
        wr_pv  = app_t_r;
      end
      S_LSCAN:   rd_addr = head_r[qsel];
      S_LOUT:    rd_addr = rd_nx;
      default:   rd_addr = cur_r;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      ne_r    <= '0;
      out_v_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r   <= in_item.operation;
            id_r   <= AW'(in_item.process_id);
            id4_r  <= in_item.process_id;
            idok_r <= int'(in_item.process_id) < NUM_PROCS;
            preq_r <= in_item.priority_req;
            cls_r  <= in_item.process_class;
            sel_r  <= in_item.queue_select;
          end
        end
        S_DEC: begin
          lnk_n_r    <= rd_nx;
          lnk_p_r    <= rd_pv;
          unl_q_r    <= rd_st;
          ins_q_r    <= dec_new_st;
          do_ins_r   <= (op_r != OP_DELETE);
          fin_r      <= (op_r != OP_DELETE);
          ent_prio_r <= dec_prio;
          ent_cls_r  <= (op_r == OP_CREATE) ? cls_r : rd_cl;
          ent_st_r   <= dec_new_st;
          qcnt_r     <= (sel_r == SEL_ALL) ? 3'd0 : sel_r - 3'd1;
          lastq_r    <= (sel_r == SEL_ALL) ? PST_SBLK : 2'(sel_r - 3'd1);
          any_r      <= 1'b0;
          if (!dec_err && op_r == OP_CREATE) valid_r[id_r] <= 1'b1;
          if (!dec_err && op_r == OP_DELETE && pres) valid_r[id_r] <= 1'b0;
          if (dec_err) begin
            out_v_r <= 1'b1;
            out_r   <= mk_res(dec_code, 1'b0, 4'd0, 8'd0, 1'b0, 2'd0, 1'b1);
          end else if (dec_show) begin
            out_v_r <= 1'b1;
            out_r   <= mk_res(STS_OK, 1'b1, id4_r, rd_pr, rd_cl, rd_st, 1'b1);
          end
        end
        S_UNL1: begin
          if (ne_r[unl_q_r]) begin
            if (head_r[unl_q_r] == id_r && tail_r[unl_q_r] == id_r) begin
              ne_r[unl_q_r] <= 1'b0;
            end else begin
              if (head_r[unl_q_r] == id_r) head_r[unl_q_r] <= lnk_n_r;
              if (tail_r[unl_q_r] == id_r) tail_r[unl_q_r] <= lnk_p_r;
            end
          end
        end
        S_INS: cur_r <= head_r[ins_q_r];
        S_INS_CMP: begin
          if (lt) begin
            ins_p_r   <= rd_pv;
            at_head_r <= (cur_r == head_r[ins_q_r]);
            if (cur_r == head_r[ins_q_r]) head_r[ins_q_r] <= id_r;
          end else if (cur_r != tail_r[ins_q_r]) begin
            cur_r <= rd_nx;
          end
        end
        S_APP1: begin
          if (!ne_r[ins_q_r]) begin
            head_r[ins_q_r] <= id_r;
            tail_r[ins_q_r] <= id_r;
            ne_r[ins_q_r]   <= 1'b1;
          end else begin
            app_t_r         <= tail_r[ins_q_r];
            tail_r[ins_q_r] <= id_r;
          end
        end
        S_DONE: begin
          out_v_r <= 1'b1;
          out_r   <= mk_res(STS_OK, 1'b1, id4_r, ent_prio_r, ent_cls_r, ent_st_r, 1'b1);
        end
        S_LSCAN: begin
          if (qcnt_r > {1'b0, lastq_r}) begin
            // empty listing
            if (!any_r) begin
              out_v_r <= 1'b1;
              out_r   <= mk_res(STS_OK, 1'b0, 4'd0, 8'd0, 1'b0, 2'd0, 1'b1);
            end
          end else if (ne_r[qsel]) begin
            cur_r <= head_r[qsel];
          end else begin
            qcnt_r <= qcnt_r + 3'd1;
          end
        end
        S_LOUT: begin
          out_v_r <= 1'b1;
          any_r   <= 1'b1;
          out_r   <= mk_res(STS_OK, 1'b1, 4'(cur_r), rd_pr, rd_cl, rd_st,
                            (cur_r == tail_r[qsel]) && !later);
          if (cur_r == tail_r[qsel]) qcnt_r <= qcnt_r + 3'd1;
          else cur_r <= rd_nx;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_v_r;
  assign out_item   = out_r;

`ifndef SYNTHESIS
  // An accepted item always starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but sequencer idle");

  // A result that is not the last one leaves the block still working
  a_more_results: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |-> busy)
    else $error("non-final result with sequencer idle");

  // Error results carry no entry and end the item
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status != STS_OK |-> !out_item.entry_present && out_item.last)
    else $error("malformed error result");

  // Results only come from work in progress
  a_res_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a command in progress");
`endif

endmodule
